// File: rtl/core/bbf_pkg.sv
// Shared types and constants for the bounded byte FIFO.
// Used by the interfaces, the front and back modules and the top level.
package bbf_pkg;

  localparam int OP_W   = 3;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 13;
  localparam int TOT_W  = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_END   = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_END,
    CMD_PEEK,
    CMD_POP,
    CMD_READ,
    CMD_STATUS
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [BYTE_W-1:0]      data;
    logic [CNT_W-1:0]       length;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

// File: rtl/core/bbf_item_if.sv
// Input channel of the bounded byte FIFO: one operation per transaction.
// Depends on bbf_pkg for field widths.
interface bbf_item_if;
  logic                        valid;
  logic                        ready;
  logic [bbf_pkg::OP_W-1:0]    op;
  logic [bbf_pkg::BYTE_W-1:0]  data_byte;
  logic [bbf_pkg::CNT_W-1:0]   length;

  modport source (output valid, output op, output data_byte, output length, input ready);
  modport sink   (input valid, input op, input data_byte, input length, output ready);
endinterface

// File: rtl/core/bbf_result_if.sv
// Result channel of the bounded byte FIFO: one result per transaction.
// Depends on bbf_pkg for field widths.
interface bbf_result_if;
  logic                        valid;
  logic                        ready;
  logic [bbf_pkg::BYTE_W-1:0]  out_byte;
  logic                        byte_valid;
  logic                        last;
  logic                        accepted;
  logic [bbf_pkg::CNT_W-1:0]   occupancy;
  logic [bbf_pkg::CNT_W-1:0]   space_left;
  logic                        ended;
  logic                        at_eof;
  logic [bbf_pkg::TOT_W-1:0]   total_written;
  logic [bbf_pkg::TOT_W-1:0]   total_read;

  modport source (output valid, output out_byte, output byte_valid, output last,
                  output accepted, output occupancy, output space_left, output ended,
                  output at_eof, output total_written, output total_read, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last,
                  input accepted, input occupancy, input space_left, input ended,
                  input at_eof, input total_written, input total_read, output ready);
endinterface

// File: rtl/core/bbf_front.sv
// Front end: accepts operations, classifies them into commands and holds
// them in a two-entry queue for the back end. Depends on bbf_pkg, bbf_item_if.
module bbf_front #(
  parameter int MAX_RUN = 64
) (
  input  logic                clk,
  input  logic                rst,
  bbf_item_if.sink            item,
  output logic                q_valid,
  output bbf_pkg::cmd_t       q_cmd,
  input  logic                q_pop
);

  bbf_pkg::cmd_t  slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  bbf_pkg::cmd_t  cmd_in;

  assign item.ready = (count != 2'd2);
  assign push       = item.valid && item.ready;
  assign q_valid    = (count != 2'd0);
  assign q_cmd      = slots[rd_ptr];

  always_comb begin
    cmd_in.data   = item.data_byte;
    cmd_in.length = item.length;
    case (item.op)
      bbf_pkg::OP_WRITE: cmd_in.kind = bbf_pkg::CMD_WRITE;
      bbf_pkg::OP_END:   cmd_in.kind = bbf_pkg::CMD_END;
      bbf_pkg::OP_PEEK:  cmd_in.kind = bbf_pkg::CMD_PEEK;
      bbf_pkg::OP_POP:   cmd_in.kind = bbf_pkg::CMD_POP;
      bbf_pkg::OP_READ:  cmd_in.kind = bbf_pkg::CMD_READ;
      default:           cmd_in.kind = bbf_pkg::CMD_STATUS;
    endcase
    // saturate run lengths here so the back end sees at most MAX_RUN
    if ((cmd_in.kind == bbf_pkg::CMD_PEEK || cmd_in.kind == bbf_pkg::CMD_READ) &&
        (32'(item.length) > 32'(MAX_RUN))) begin
      cmd_in.length = bbf_pkg::CNT_W'(MAX_RUN);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/bbf_back.sv
// Back end: byte storage, pointers, counters and the result register.
// Executes one queued command at a time. Depends on bbf_pkg, bbf_result_if.
module bbf_back #(
  parameter int DEPTH   = 4096,
  parameter int MAX_RUN = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bbf_pkg::CNT_W-1:0]   cfg_wdata,
  input  logic                        q_valid,
  input  bbf_pkg::cmd_t               q_cmd,
  output logic                        q_pop,
  bbf_result_if.source                result
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = ((AW > bbf_pkg::CNT_W) ? AW : bbf_pkg::CNT_W) + 1;
  localparam int RW = (MAX_RUN > 1) ? $clog2(MAX_RUN + 1) : 1;

  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  logic [bbf_pkg::BYTE_W-1:0] mem [DEPTH];

  bbf_pkg::back_state_t        state, state_next;
  logic [bbf_pkg::CNT_W-1:0]   cap;
  logic [AW-1:0]               head, head_next;
  logic [bbf_pkg::CNT_W-1:0]   fill, fill_next;
  logic [bbf_pkg::TOT_W-1:0]   wcnt, wcnt_next;
  logic [bbf_pkg::TOT_W-1:0]   rcnt, rcnt_next;
  logic                        end_flag, end_next;
  logic [AW-1:0]               ptr, ptr_next;
  logic [RW-1:0]               remain, remain_next;

  logic                        out_valid;
  logic [bbf_pkg::BYTE_W-1:0]  rd_data;
  logic                        bvalid, last_r, acc_r;
  logic [bbf_pkg::CNT_W-1:0]   st_occ, st_space;
  logic                        st_end;
  logic [bbf_pkg::TOT_W-1:0]   st_wcnt, st_rcnt;

  logic                        adv, take, load;
  logic                        ld_bvalid, ld_last, ld_acc;
  logic                        mem_we, rd_en;
  logic [AW-1:0]               rd_addr, tail;
  logic [bbf_pkg::CNT_W-1:0]   eff_cap, space_next, n;
  logic [SW-1:0]               tail_sum, head_sum;

  assign eff_cap = (32'(cap) > 32'(DEPTH)) ? bbf_pkg::CNT_W'(DEPTH) : cap;

  assign adv   = !out_valid || result.ready;
  assign take  = (state == bbf_pkg::BK_IDLE) && q_valid && adv;
  assign q_pop = take;

  // count of bytes a pop, peek or read acts on (run lengths come pre-clamped)
  assign n = (q_cmd.length < fill) ? q_cmd.length : fill;

  // tail and advanced head wrap at most once, so one compare and subtract
  assign tail_sum = SW'(head) + SW'(fill);
  assign tail     = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign head_sum = SW'(head) + SW'(n);

  always_comb begin
    state_next  = state;
    head_next   = head;
    fill_next   = fill;
    wcnt_next   = wcnt;
    rcnt_next   = rcnt;
    end_next    = end_flag;
    ptr_next    = ptr;
    remain_next = remain;
    load        = 1'b0;
    ld_bvalid   = 1'b0;
    ld_last     = 1'b1;
    ld_acc      = 1'b0;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = head;
    case (state)
      bbf_pkg::BK_IDLE: begin
        if (take) begin
          load = 1'b1;
          case (q_cmd.kind)
            bbf_pkg::CMD_WRITE: begin
              if (fill < eff_cap) begin
                mem_we    = 1'b1;
                ld_acc    = 1'b1;
                fill_next = fill + 1'b1;
                wcnt_next = wcnt + 1'b1;
              end
            end
            bbf_pkg::CMD_END: begin
              end_next = 1'b1;
            end
            bbf_pkg::CMD_POP: begin
              head_next = (head_sum >= DEPTH_S) ? AW'(head_sum - DEPTH_S) : AW'(head_sum);
              fill_next = fill - n;
              rcnt_next = rcnt + bbf_pkg::TOT_W'(n);
            end
            bbf_pkg::CMD_PEEK, bbf_pkg::CMD_READ: begin
              if (n != '0) begin
                // first byte goes out now, the rest follow from ptr
                rd_en       = 1'b1;
                ld_bvalid   = 1'b1;
                ld_last     = (n == bbf_pkg::CNT_W'(1));
                ptr_next    = (head == LAST_A) ? '0 : head + 1'b1;
                remain_next = RW'(n - 1'b1);
                if (n != bbf_pkg::CNT_W'(1)) begin
                  state_next = bbf_pkg::BK_RUN;
                end
                if (q_cmd.kind == bbf_pkg::CMD_READ) begin
                  head_next = (head_sum >= DEPTH_S) ? AW'(head_sum - DEPTH_S)
                                                    : AW'(head_sum);
                  fill_next = fill - n;
                  rcnt_next = rcnt + bbf_pkg::TOT_W'(n);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      bbf_pkg::BK_RUN: begin
        if (adv) begin
          load        = 1'b1;
          rd_en       = 1'b1;
          rd_addr     = ptr;
          ld_bvalid   = 1'b1;
          ld_last     = (remain == RW'(1));
          ptr_next    = (ptr == LAST_A) ? '0 : ptr + 1'b1;
          remain_next = remain - 1'b1;
          if (remain == RW'(1)) begin
            state_next = bbf_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_next = bbf_pkg::BK_IDLE;
      end
    endcase
  end

  assign space_next = (eff_cap > fill_next) ? eff_cap - fill_next : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= q_cmd.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // result payload; status is captured once per command and held across a run
  always_ff @(posedge clk) begin
    if (load) begin
      bvalid <= ld_bvalid;
      last_r <= ld_last;
      acc_r  <= ld_acc;
    end
    if (take) begin
      st_occ   <= fill_next;
      st_space <= space_next;
      st_end   <= end_next;
      st_wcnt  <= wcnt_next;
      st_rcnt  <= rcnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bbf_pkg::BK_IDLE;
      cap       <= bbf_pkg::CAP_RESET;
      head      <= '0;
      fill      <= '0;
      wcnt      <= '0;
      rcnt      <= '0;
      end_flag  <= 1'b0;
      ptr       <= '0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      fill     <= fill_next;
      wcnt     <= wcnt_next;
      rcnt     <= rcnt_next;
      end_flag <= end_next;
      ptr      <= ptr_next;
      remain   <= remain_next;
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      if (adv) begin
        out_valid <= load;
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.out_byte      = bvalid ? rd_data : '0;
  assign result.byte_valid    = bvalid;
  assign result.last          = last_r;
  assign result.accepted      = acc_r;
  assign result.occupancy     = st_occ;
  assign result.space_left    = st_space;
  assign result.ended         = st_end;
  assign result.at_eof        = st_end && (st_occ == '0);
  assign result.total_written = st_wcnt;
  assign result.total_read    = st_rcnt;

endmodule

// File: rtl/core/bounded_byte_fifo.sv
// Top level of the bounded byte FIFO: front end with command queue and
// back end with storage. Depends on bbf_pkg, bbf_item_if, bbf_result_if.
//
//   channel  | direction | handshake    | payload
//   item     | in        | valid/ready  | op, data_byte, length
//   result   | out       | valid/ready  | out_byte .. total_read (10 fields)
//   cfg      | in        | cfg_we       | cfg_wdata = fifo_capacity
//
// Write, end, pop and unknown ops are done when taken. Peek and read of n bytes give
// max(n,1) results, one read per cycle unless the result stalls, on the storage
// memory's single read port, whose registered data is the result byte.
// A two-entry command queue lets items arrive while a run drains.
// Reset clears pointers, counters and flags at once; storage is not cleared.
// A stalled result holds the back end; the queue then fills and drops item.ready.
module bounded_byte_fifo #(
  parameter int DEPTH   = 4096,
  parameter int MAX_RUN = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bbf_pkg::CNT_W-1:0]  cfg_wdata,
  bbf_item_if.sink                   item,
  bbf_result_if.source               result
);

  logic          q_valid;
  logic          q_pop;
  bbf_pkg::cmd_t q_cmd;

  bbf_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  bbf_back #(
    .DEPTH   (DEPTH),
    .MAX_RUN (MAX_RUN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .result    (result)
  );

endmodule
